// ===== hw/rtl/mi3_pkg.sv =====
// shared constants for the 3x3 fixed-point matrix inverse
// cofactor index tables, field widths and default sizes; no dependencies

package mi3_pkg;

  localparam int unsigned FIELD_W        = 32;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned N_ELEM         = 9;
  localparam int unsigned N_DET          = 3;
  // register stages in the cofactor / determinant front end
  localparam int unsigned FRONT_ST       = 7;

  typedef logic [3:0] idx_t;

  // adjugate entry k = m[a]*m[b] - m[c]*m[d], row-major element indices
  localparam idx_t COF_IDX [N_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // determinant expands along row 0 using adjugate column 0
  localparam idx_t DET_IDX [N_DET] = '{4'd0, 4'd3, 4'd6};

endpackage

// ===== hw/rtl/mi3_if.sv =====
// valid/ready channels for the matrix inverse: matrix in, inverse out
// field widths come from mi3_pkg

interface mi3_mat_if;
  logic                          valid;
  logic                          ready;
  logic [mi3_pkg::FIELD_W-1:0]   m00, m01, m02, m10, m11, m12, m20, m21, m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface mi3_inv_if;
  logic                          valid;
  logic                          ready;
  logic [mi3_pkg::FIELD_W-1:0]   inv00, inv01, inv02, inv10, inv11, inv12;
  logic [mi3_pkg::FIELD_W-1:0]   inv20, inv21, inv22;
  logic                          singular;
  logic                          saturated;

  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, singular, saturated, input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, singular, saturated, output ready);
endinterface

// ===== hw/rtl/mi3_front.sv =====
// cofactor and determinant front end: products, adjugate, determinant, magnitudes
// uses mi3_pkg index tables; stage enables come from the top level

module mi3_front #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic [mi3_pkg::FRONT_ST-1:0]                en_i,
  input  logic [mi3_pkg::FIELD_W-1:0]                 m_i [mi3_pkg::N_ELEM],
  output logic [2*DATA_WIDTH+1+2*FRAC_BITS-1:0]       nmag_o [mi3_pkg::N_ELEM],
  output logic                                        nneg_o [mi3_pkg::N_ELEM],
  output logic [3*DATA_WIDTH+3-1:0]                   dmag_o,
  output logic                                        dneg_o,
  output logic                                        sing_o
);
  import mi3_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned ADJW = 2*DW+1;
  localparam int unsigned DETW = 3*DW+3;
  localparam int unsigned NW   = ADJW+2*FRAC_BITS;

  logic signed [DW-1:0]     m_q    [N_ELEM];
  logic signed [2*DW-1:0]   p_q    [2*N_ELEM];
  logic signed [DW-1:0]     mr1_q  [N_DET];
  logic signed [DW-1:0]     mr2_q  [N_DET];
  logic signed [ADJW-1:0]   adj_q  [N_ELEM];
  logic signed [ADJW-1:0]   adj3_q [N_ELEM];
  logic signed [ADJW-1:0]   adj4_q [N_ELEM];
  logic signed [ADJW-1:0]   adj5_q [N_ELEM];
  logic signed [2*DW:0]     plo_q  [N_DET];
  logic signed [2*DW:0]     phi_q  [N_DET];
  logic signed [DETW-1:0]   term_q [N_DET];
  logic signed [DETW-1:0]   det_q;
  logic [NW-1:0]            nmag_q [N_ELEM];
  logic                     nneg_q [N_ELEM];
  logic [DETW-1:0]          dmag_q;
  logic                     dneg_q;
  logic                     sing_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < N_ELEM; k++) m_q[k] <= $signed(m_i[k][DW-1:0]);
    end
    if (en_i[1]) begin
      for (int k = 0; k < N_ELEM; k++) begin
        p_q[2*k]   <= m_q[COF_IDX[k][0]] * m_q[COF_IDX[k][1]];
        p_q[2*k+1] <= m_q[COF_IDX[k][2]] * m_q[COF_IDX[k][3]];
      end
      for (int j = 0; j < N_DET; j++) mr1_q[j] <= m_q[j];
    end
    if (en_i[2]) begin
      for (int k = 0; k < N_ELEM; k++) adj_q[k] <= ADJW'(p_q[2*k]) - ADJW'(p_q[2*k+1]);
      mr2_q <= mr1_q;
    end
    // split each det product into a low unsigned and a high signed half
    if (en_i[3]) begin
      for (int j = 0; j < N_DET; j++) begin
        plo_q[j] <= mr2_q[j] * $signed({1'b0, adj_q[DET_IDX[j]][DW-1:0]});
        phi_q[j] <= mr2_q[j] * $signed(adj_q[DET_IDX[j]][ADJW-1:DW]);
      end
      adj3_q <= adj_q;
    end
    if (en_i[4]) begin
      for (int j = 0; j < N_DET; j++) begin
        term_q[j] <= (DETW'(phi_q[j]) <<< DW) + DETW'(plo_q[j]);
      end
      adj4_q <= adj3_q;
    end
    if (en_i[5]) begin
      det_q  <= term_q[0] + term_q[1] + term_q[2];
      adj5_q <= adj4_q;
    end
    if (en_i[6]) begin
      for (int k = 0; k < N_ELEM; k++) begin
        nneg_q[k] <= adj5_q[k][ADJW-1];
        nmag_q[k] <= NW'(adj5_q[k][ADJW-1] ? ADJW'(-adj5_q[k]) : adj5_q[k]) << (2*FRAC_BITS);
      end
      dneg_q <= det_q[DETW-1];
      dmag_q <= det_q[DETW-1] ? DETW'(-det_q) : det_q;
      sing_q <= (det_q == '0);
    end
  end

  assign nmag_o = nmag_q;
  assign nneg_o = nneg_q;
  assign dmag_o = dmag_q;
  assign dneg_o = dneg_q;
  assign sing_o = sing_q;

endmodule

// ===== hw/rtl/mi3_div_lane.sv =====
// one divider lane: pipelined restoring division, one quotient bit per stage,
// then sign and saturation; depends on mi3_pkg

module mi3_div_lane #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic [DATA_WIDTH+2:0]                   en_i,
  input  logic [2*DATA_WIDTH+1+2*FRAC_BITS-1:0]   nmag_i,
  input  logic                                    nneg_i,
  input  logic [3*DATA_WIDTH+3-1:0]               dmag_i,
  input  logic                                    dneg_i,
  input  logic                                    sing_i,
  output logic [DATA_WIDTH-1:0]                   val_o,
  output logic                                    sat_o,
  output logic                                    sing_o
);
  import mi3_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned DETW = 3*DW+3;
  localparam int unsigned NW   = 2*DW+1+2*FRAC_BITS;
  localparam int unsigned QW   = DW+1;
  localparam int unsigned RW   = (NW > DETW+QW) ? NW : DETW+QW;
  localparam logic [QW-1:0] POS_MAX = QW'((64'd1 << (DW-1)) - 64'd1);
  localparam logic [QW-1:0] NEG_MAG = QW'(64'd1 << (DW-1));

  logic [RW-1:0]   r_q    [QW+1];
  logic [QW-1:0]   q_q    [QW+1];
  logic [DETW-1:0] d_q    [QW+1];
  logic            neg_q  [QW+1];
  logic            ovf_q  [QW+1];
  logic            sing_q [QW+1];
  logic [DW-1:0]   val_q;
  logic            sat_q;
  logic            fsing_q;

  // quotient needs QW bits; anything larger is caught up front
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0]    <= RW'(nmag_i);
      q_q[0]    <= '0;
      d_q[0]    <= dmag_i;
      neg_q[0]  <= nneg_i ^ dneg_i;
      ovf_q[0]  <= RW'(nmag_i) >= (RW'(dmag_i) << QW);
      sing_q[0] <= sing_i;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int unsigned B = QW - j;
    logic [RW-1:0] dsh;
    logic          ge;
    assign dsh = RW'(d_q[j-1]) << B;
    assign ge  = r_q[j-1] >= dsh;
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        r_q[j]    <= ge ? r_q[j-1] - dsh : r_q[j-1];
        q_q[j]    <= q_q[j-1] | (QW'(ge) << B);
        d_q[j]    <= d_q[j-1];
        neg_q[j]  <= neg_q[j-1];
        ovf_q[j]  <= ovf_q[j-1];
        sing_q[j] <= sing_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[QW+1]) begin
      fsing_q <= sing_q[QW];
      if (neg_q[QW]) begin
        if (ovf_q[QW] || q_q[QW] > NEG_MAG) begin
          sat_q <= 1'b1;
          val_q <= DW'(NEG_MAG);
        end else begin
          sat_q <= 1'b0;
          val_q <= DW'(-q_q[QW]);
        end
      end else begin
        if (ovf_q[QW] || q_q[QW] > POS_MAX) begin
          sat_q <= 1'b1;
          val_q <= DW'(POS_MAX);
        end else begin
          sat_q <= 1'b0;
          val_q <= DW'(q_q[QW]);
        end
      end
    end
  end

  assign val_o  = val_q;
  assign sat_o  = sat_q;
  assign sing_o = fsing_q;

endmodule

// ===== hw/rtl/mi3_merge.sv =====
// merging stage: gathers the nine lanes, applies the singular case and
// combines saturation flags into the output register; depends on mi3_pkg

module mi3_merge #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [DATA_WIDTH-1:0]         val_i [mi3_pkg::N_ELEM],
  input  logic [mi3_pkg::N_ELEM-1:0]    sat_i,
  input  logic                          sing_i,
  output logic [mi3_pkg::FIELD_W-1:0]   inv_o [mi3_pkg::N_ELEM],
  output logic                          singular_o,
  output logic                          saturated_o
);
  import mi3_pkg::*;

  logic [FIELD_W-1:0] inv_q [N_ELEM];
  logic               singular_q;
  logic               saturated_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N_ELEM; k++) begin
        inv_q[k] <= sing_i ? '0 : FIELD_W'($signed(val_i[k]));
      end
      singular_q  <= sing_i;
      saturated_q <= !sing_i && (|sat_i);
    end
  end

  assign inv_o       = inv_q;
  assign singular_o  = singular_q;
  assign saturated_o = saturated_q;

endmodule

// ===== hw/rtl/matrix_inverse_3x3.sv =====
// top level of the 3x3 fixed-point matrix inverse (adjugate over determinant)
// uses mi3_pkg, mi3_if, mi3_front, mi3_div_lane, mi3_merge
//
//   channel   dir   content
//   mat_i     in    nine signed matrix elements m00..m22
//   inv_o     out   nine inverse elements, singular, saturated
//
// one matrix per cycle unless inv_o.ready holds the output; the stages are:
// seven front-end stages, then DATA_WIDTH+1 divider stages, one per quotient bit,
// plus entry, sign/saturate and output register stages
// every stage holds a valid bit; a stage loads when it is empty or moves on,
// so bubbles close up, and input is taken while a result waits at the output if
// any stage is still empty; reset clears the valid bits only

module matrix_inverse_3x3 #(
  parameter int unsigned DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  mi3_mat_if.sink   mat_i,
  mi3_inv_if.source inv_o
);
  import mi3_pkg::*;

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned DETW = 3*DW+3;
  localparam int unsigned NW   = 2*DW+1+2*FRAC_BITS;
  localparam int unsigned LST  = DW+3;
  localparam int unsigned NST  = FRONT_ST + LST + 1;

  logic [NST-1:0]      v_q;
  logic [NST-1:0]      en;
  logic [FIELD_W-1:0]  m_in   [N_ELEM];
  logic [NW-1:0]       nmag   [N_ELEM];
  logic                nneg   [N_ELEM];
  logic [DETW-1:0]     dmag;
  logic                dneg;
  logic                sing;
  logic [DW-1:0]       val    [N_ELEM];
  logic [N_ELEM-1:0]   sat;
  logic                lsing  [N_ELEM];
  logic [FIELD_W-1:0]  inv    [N_ELEM];

  // stage enables ripple back from the output
  assign en[NST-1] = !v_q[NST-1] || inv_o.ready;
  for (genvar k = 0; k < NST-1; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= mat_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign mat_i.ready = en[0];

  assign m_in[0] = mat_i.m00;
  assign m_in[1] = mat_i.m01;
  assign m_in[2] = mat_i.m02;
  assign m_in[3] = mat_i.m10;
  assign m_in[4] = mat_i.m11;
  assign m_in[5] = mat_i.m12;
  assign m_in[6] = mat_i.m20;
  assign m_in[7] = mat_i.m21;
  assign m_in[8] = mat_i.m22;

  mi3_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .en_i   (en[FRONT_ST-1:0]),
    .m_i    (m_in),
    .nmag_o (nmag),
    .nneg_o (nneg),
    .dmag_o (dmag),
    .dneg_o (dneg),
    .sing_o (sing)
  );

  for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
    mi3_div_lane #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en[FRONT_ST+LST-1:FRONT_ST]),
      .nmag_i (nmag[k]),
      .nneg_i (nneg[k]),
      .dmag_i (dmag),
      .dneg_i (dneg),
      .sing_i (sing),
      .val_o  (val[k]),
      .sat_o  (sat[k]),
      .sing_o (lsing[k])
    );
  end

  mi3_merge #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_merge (
    .clk_i       (clk_i),
    .en_i        (en[NST-1]),
    .val_i       (val),
    .sat_i       (sat),
    .sing_i      (lsing[0]),
    .inv_o       (inv),
    .singular_o  (inv_o.singular),
    .saturated_o (inv_o.saturated)
  );

  assign inv_o.valid = v_q[NST-1];
  assign inv_o.inv00 = inv[0];
  assign inv_o.inv01 = inv[1];
  assign inv_o.inv02 = inv[2];
  assign inv_o.inv10 = inv[3];
  assign inv_o.inv11 = inv[4];
  assign inv_o.inv12 = inv[5];
  assign inv_o.inv20 = inv[6];
  assign inv_o.inv21 = inv[7];
  assign inv_o.inv22 = inv[8];

endmodule
